[rtl/core/ace_pkg.sv]
// ----------------------------------------------------------------------------
// ace_pkg
// Shared widths, limits and state types of the arithmetic encoder core.
// ----------------------------------------------------------------------------
package ace_pkg;

  localparam int unsigned DEF_CODE_BITS = 16;
  localparam int unsigned FREQ_BITS     = 14;
  localparam int unsigned CUM_W         = FREQ_BITS;
  localparam int unsigned TOT_W         = FREQ_BITS + 1;
  localparam int unsigned CNT_W         = 16;
  localparam logic [CNT_W-1:0] PENDING_MAX = {CNT_W{1'b1}};
  localparam int unsigned RESULT_CAP    = 17;
  localparam int unsigned RES_CNT_W     = $clog2(RESULT_CAP + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_A,
    ST_WAIT_A,
    ST_START_B,
    ST_WAIT_B,
    ST_RENORM,
    ST_FLUSH,
    ST_FINISH
  } enc_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

[rtl/core/ace_if.sv]
// ----------------------------------------------------------------------------
// ace_if
// Valid/ready channels of the encoder: symbol input and run output.
// ----------------------------------------------------------------------------
interface ace_sym_if import ace_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CUM_W-1:0] cum_low;
  logic [TOT_W-1:0] cum_high;
  logic [TOT_W-1:0] total_count;
  logic             flush;

  modport source (output valid, cum_low, cum_high, total_count, flush, input ready);
  modport sink   (input valid, cum_low, cum_high, total_count, flush, output ready);
endinterface

interface ace_run_if import ace_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             out_bit;
  logic [CNT_W-1:0] follow_count;
  logic             last;

  modport source (output valid, out_bit, follow_count, last, input ready);
  modport sink   (input valid, out_bit, follow_count, last, output ready);
endinterface

[rtl/core/ace_div_unit.sv]
// ----------------------------------------------------------------------------
// ace_div_unit
// Scaling unit: quotient of len * mult / total, one multiply then one
// restoring division step per cycle.
// ----------------------------------------------------------------------------
module ace_div_unit import ace_pkg::*; #(
  parameter int unsigned CODE_BITS = DEF_CODE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CODE_BITS:0]   len_i,
  input  logic [TOT_W-1:0]     mult_i,
  input  logic [TOT_W-1:0]     total_i,
  output logic                 done_o,
  output logic [CODE_BITS:0]   quot_o
);

  localparam int unsigned QW  = CODE_BITS + 1;
  localparam int unsigned PW  = QW + TOT_W;
  localparam int unsigned CW  = $clog2(QW + 1);

  div_state_e      state_q, state_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [TOT_W-1:0] rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [TOT_W:0]  trial;
  logic [TOT_W:0]  diff;
  logic            ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign trial = {rem_q, quo_q[QW-1]};
  assign diff  = trial - {1'b0, total_i};
  assign ge    = (trial >= {1'b0, total_i});

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          prod_d  = {{TOT_W{1'b0}}, len_i} * {{QW{1'b0}}, mult_i};
          state_d = DIV_MUL;
        end
      end
      DIV_MUL: begin
        // upper part of the product is already below total
        rem_d   = prod_q[PW-1 -: TOT_W];
        quo_d   = prod_q[QW-1:0];
        cnt_d   = CW'(QW);
        state_d = DIV_RUN;
      end
      DIV_RUN: begin
        rem_d = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
        quo_d = {quo_q[QW-2:0], ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  assign done_o = (state_q == DIV_DONE);
  assign quot_o = quo_q;

endmodule

[rtl/core/arithmetic_encoder_core.sv]
// ----------------------------------------------------------------------------
// arithmetic_encoder_core
// Integer arithmetic encoder: narrows the code range per symbol,
// renormalizes and hands out runs of one bit plus inverted follow bits.
// ----------------------------------------------------------------------------
// One symbol at a time. After a transfer on sym_i the block scales the range
// twice in a shared multiply and bit-serial divide unit, then shifts once per
// cycle during renormalization (up to CODE_BITS shifts), stalling while an
// emitted run cannot be passed on to run_o, then runs a flush step if one was
// asked and a closing step that ends the item. Each emitted run is held one
// step so that the last run of an item carries last. Inputs with an invalid
// interval only carry out the flush, if any, and close the item.
module arithmetic_encoder_core import ace_pkg::*; #(
  parameter int unsigned CODE_BITS = DEF_CODE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ace_sym_if.sink       sym_i,
  ace_run_if.source     run_o
);

  localparam int unsigned IW = $clog2(CODE_BITS + 1);

  enc_state_e             state_q, state_d;
  logic [CUM_W-1:0]       cl_q, cl_d;
  logic [TOT_W-1:0]       ch_q, ch_d;
  logic [TOT_W-1:0]       tot_q, tot_d;
  logic                   flush_q, flush_d;
  logic [CODE_BITS-1:0]   low_q, low_d;
  logic [CODE_BITS-1:0]   high_q, high_d;
  logic [CNT_W-1:0]       pend_q, pend_d;
  logic [CODE_BITS:0]     a_q, a_d;
  logic [IW-1:0]          iter_q, iter_d;
  logic [RES_CNT_W-1:0]   res_cnt_q, res_cnt_d;
  logic                   hold_vld_q, hold_vld_d;
  logic                   hold_bit_q, hold_bit_d;
  logic [CNT_W-1:0]       hold_cnt_q, hold_cnt_d;
  logic                   ov_q, ov_d;
  logic                   obit_q, obit_d;
  logic [CNT_W-1:0]       ocnt_q, ocnt_d;
  logic                   olast_q, olast_d;

  logic                   div_start;
  logic [TOT_W-1:0]       div_mult;
  logic                   div_done;
  logic [CODE_BITS:0]     div_quot;
  logic [CODE_BITS:0]     len;
  logic [CODE_BITS:0]     high_sum;
  logic [CNT_W-1:0]       pend_inc;
  logic                   out_free;
  logic                   cap_full;
  logic                   emit_ok;
  logic                   emit_req;
  logic                   emit_bit;
  logic [CNT_W-1:0]       emit_cnt;
  logic                   in_ok;

  assign len      = {1'b0, high_q} - {1'b0, low_q} + (CODE_BITS+1)'(1);
  assign high_sum = {1'b0, low_q} + div_quot - (CODE_BITS+1)'(1);
  assign pend_inc = (pend_q == PENDING_MAX) ? pend_q : pend_q + CNT_W'(1);
  assign out_free = !ov_q || run_o.ready;
  assign cap_full = (res_cnt_q >= RES_CNT_W'(RESULT_CAP));
  assign emit_ok  = cap_full || !hold_vld_q || out_free;
  assign in_ok    = (sym_i.total_count != '0) && (sym_i.cum_high <= sym_i.total_count)
                    && ({1'b0, sym_i.cum_low} < sym_i.cum_high);

  ace_div_unit #(
    .CODE_BITS (CODE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .len_i   (len),
    .mult_i  (div_mult),
    .total_i (tot_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      low_q      <= '0;
      high_q     <= '1;
      pend_q     <= '0;
      iter_q     <= '0;
      res_cnt_q  <= '0;
      hold_vld_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      low_q      <= low_d;
      high_q     <= high_d;
      pend_q     <= pend_d;
      iter_q     <= iter_d;
      res_cnt_q  <= res_cnt_d;
      hold_vld_q <= hold_vld_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q       <= cl_d;
    ch_q       <= ch_d;
    tot_q      <= tot_d;
    flush_q    <= flush_d;
    a_q        <= a_d;
    hold_bit_q <= hold_bit_d;
    hold_cnt_q <= hold_cnt_d;
    obit_q     <= obit_d;
    ocnt_q     <= ocnt_d;
    olast_q    <= olast_d;
  end

  always_comb begin
    state_d    = state_q;
    cl_d       = cl_q;
    ch_d       = ch_q;
    tot_d      = tot_q;
    flush_d    = flush_q;
    low_d      = low_q;
    high_d     = high_q;
    pend_d     = pend_q;
    a_d        = a_q;
    iter_d     = iter_q;
    res_cnt_d  = res_cnt_q;
    hold_vld_d = hold_vld_q;
    hold_bit_d = hold_bit_q;
    hold_cnt_d = hold_cnt_q;
    ov_d       = ov_q;
    obit_d     = obit_q;
    ocnt_d     = ocnt_q;
    olast_d    = olast_q;
    sym_i.ready = 1'b0;
    div_start  = 1'b0;
    div_mult   = {1'b0, cl_q};
    emit_req   = 1'b0;
    emit_bit   = 1'b0;
    emit_cnt   = pend_q;

    if (ov_q && run_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        sym_i.ready = 1'b1;
        if (sym_i.valid) begin
          cl_d      = sym_i.cum_low;
          ch_d      = sym_i.cum_high;
          tot_d     = sym_i.total_count;
          flush_d   = sym_i.flush;
          res_cnt_d = '0;
          if (in_ok) begin
            state_d = ST_START_A;
          end else if (sym_i.flush) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_START_A: begin
        div_start = 1'b1;
        div_mult  = {1'b0, cl_q};
        state_d   = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (div_done) begin
          a_d     = div_quot;
          state_d = ST_START_B;
        end
      end
      ST_START_B: begin
        div_start = 1'b1;
        div_mult  = ch_q;
        state_d   = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (div_done) begin
          if (div_quot > a_q) begin
            high_d = high_sum[CODE_BITS-1:0];
            low_d  = low_q + a_q[CODE_BITS-1:0];
          end
          iter_d  = '0;
          state_d = ST_RENORM;
        end
      end
      ST_RENORM: begin
        if (iter_q == IW'(CODE_BITS)) begin
          state_d = flush_q ? ST_FLUSH : ST_FINISH;
        end else if (low_q[CODE_BITS-1] == high_q[CODE_BITS-1]) begin
          emit_req = 1'b1;
          emit_bit = high_q[CODE_BITS-1];
          if (emit_ok) begin
            low_d  = {low_q[CODE_BITS-2:0], 1'b0};
            high_d = {high_q[CODE_BITS-2:0], 1'b1};
            iter_d = iter_q + IW'(1);
          end
        end else if (low_q[CODE_BITS-2] && !high_q[CODE_BITS-2]) begin
          // underflow: drop the second bit, one more pending bit
          low_d  = {1'b0, low_q[CODE_BITS-3:0], 1'b0};
          high_d = {1'b1, high_q[CODE_BITS-3:0], 1'b1};
          pend_d = pend_inc;
          iter_d = iter_q + IW'(1);
        end else begin
          state_d = flush_q ? ST_FLUSH : ST_FINISH;
        end
      end
      ST_FLUSH: begin
        emit_req = 1'b1;
        emit_bit = low_q[CODE_BITS-2];
        emit_cnt = pend_inc;
        if (emit_ok) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (hold_vld_q) begin
          if (out_free) begin
            ov_d       = 1'b1;
            obit_d     = hold_bit_q;
            ocnt_d     = hold_cnt_q;
            olast_d    = 1'b1;
            hold_vld_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a new run pushes the held one out, unless the result cap is reached
    if (emit_req && emit_ok) begin
      pend_d = '0;
      if (!cap_full) begin
        if (hold_vld_q) begin
          ov_d    = 1'b1;
          obit_d  = hold_bit_q;
          ocnt_d  = hold_cnt_q;
          olast_d = 1'b0;
        end
        hold_vld_d = 1'b1;
        hold_bit_d = emit_bit;
        hold_cnt_d = emit_cnt;
        res_cnt_d  = res_cnt_q + RES_CNT_W'(1);
      end
    end
  end

  assign run_o.valid        = ov_q;
  assign run_o.out_bit      = obit_q;
  assign run_o.follow_count = ocnt_q;
  assign run_o.last         = olast_q;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_i.valid && sym_i.ready |=> !sym_i.ready)
    else $error("input taken while an item is in progress");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT_A) || (state_q == ST_WAIT_B))
    else $error("scaling unit finished outside a wait state");

  a_flush_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) && emit_ok |=> pend_q == '0)
    else $error("pending count not cleared by flush");

  a_hold_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> res_cnt_q != '0)
    else $error("held run without a result count");

endmodule

[tb/sv/arithmetic_encoder_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arithmetic_encoder_core_test
// Self-checking bench for the arithmetic encoder core. Symbols go in over the
// symbol channel. A behavioral coder tracks the code range and the pending
// count; each run transfer is checked against it or a one-run row's own run.
// A directed table comes first, then random symbols under three idling mixes,
// with one long output hold. A final stretch of centered symbols builds up a
// long pending count before a flush.
// ----------------------------------------------------------------------------
module arithmetic_encoder_core_test;
  import ace_pkg::*;

  localparam int unsigned CW           = DEF_CODE_BITS;
  localparam int unsigned MAX_CUM      = (1 << CUM_W) - 1;
  localparam int unsigned MAX_TOTAL    = 1 << FREQ_BITS;
  localparam int unsigned TOT_FULL     = (1 << TOT_W) - 1;
  localparam int unsigned RAND_ITEMS   = 110;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN        = 120;
  localparam int unsigned CENTER_ITEMS = 16;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  typedef struct {
    logic [CUM_W-1:0] cum_low;
    logic [TOT_W-1:0] cum_high;
    logic [TOT_W-1:0] total_count;
    logic             flush;
  } symbol_t;

  typedef struct {
    logic             out_bit;
    logic [CNT_W-1:0] follow_count;
    logic             last;
  } run_t;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_SILENT,
    ROW_ONE_RUN
  } row_kind_e;

  typedef struct {
    symbol_t          sym;
    row_kind_e        kind;
    logic             exp_bit;
    logic [CNT_W-1:0] exp_follow;
  } row_t;

  localparam int unsigned N_ROWS = 24;

  row_t dir_rows [N_ROWS] = '{
    '{'{0, 1, 0, 0}, ROW_SILENT, 0, 0},
    '{'{0, 1, 0, 1}, ROW_ONE_RUN, 0, 1},
    '{'{0, 5, 4, 0}, ROW_SILENT, 0, 0},
    '{'{16383, 16383, 32767, 1}, ROW_ONE_RUN, 0, 1},
    '{'{4095, 8193, 16384, 0}, ROW_MODEL, 0, 0},
    '{'{100, 101, 32767, 0}, ROW_MODEL, 0, 0},
    '{'{0, 1, 32767, 0}, ROW_MODEL, 0, 0},
    '{'{16383, 16384, 16384, 0}, ROW_MODEL, 0, 0},
    '{'{16383, 32767, 32767, 0}, ROW_MODEL, 0, 0},
    '{'{0, 16384, 16384, 1}, ROW_MODEL, 0, 0},
    '{'{1, 2, 3, 0}, ROW_MODEL, 0, 0},
    '{'{0, 32767, 32767, 1}, ROW_MODEL, 0, 0},
    '{'{8191, 8192, 16384, 0}, ROW_MODEL, 0, 0},
    '{'{10, 20, 30, 1}, ROW_MODEL, 0, 0},
    '{'{0, 1, 1, 0}, ROW_MODEL, 0, 0},
    '{'{5, 6, 32767, 1}, ROW_MODEL, 0, 0},
    '{'{12345, 12346, 16384, 0}, ROW_MODEL, 0, 0},
    '{'{2, 3, 4, 1}, ROW_MODEL, 0, 0},
    '{'{0, 1, 2, 0}, ROW_MODEL, 0, 0},
    '{'{1, 2, 2, 0}, ROW_MODEL, 0, 0},
    '{'{0, 16384, 16383, 1}, ROW_MODEL, 0, 0},
    '{'{16383, 16384, 32767, 0}, ROW_MODEL, 0, 0},
    '{'{16383, 0, 32767, 0}, ROW_MODEL, 0, 0},
    '{'{0, 32767, 16384, 1}, ROW_MODEL, 0, 0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ace_sym_if sym_ch ();
  ace_run_if run_ch ();

  arithmetic_encoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sym_i  (sym_ch),
    .run_o  (run_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // behavioral coder state
  logic [CW-1:0]    code_low;
  logic [CW-1:0]    code_high;
  logic [CNT_W-1:0] pend_cnt;
  logic [CNT_W-1:0] pend_peak;

  run_t step_runs [$];
  run_t runs_due [$];

  int unsigned src_gap_pct;
  int unsigned sink_gap_pct;
  logic        hold_req;
  bit          hold_done;
  int unsigned hold_left;
  int unsigned fail_cnt;
  int unsigned runs_checked;
  int unsigned symbols_sent;
  int unsigned flushes_sent;
  int unsigned rejected_sent;
  int unsigned cycle_cnt;

  function automatic void bump_pending();
    if (pend_cnt != PENDING_MAX) pend_cnt++;
    if (pend_cnt > pend_peak) pend_peak = pend_cnt;
  endfunction

  function automatic void put_run(input logic b);
    if (step_runs.size() < RESULT_CAP) step_runs.push_back('{b, pend_cnt, 1'b0});
    pend_cnt = '0;
  endfunction

  function automatic void code_symbol(input symbol_t s);
    logic [63:0] span;
    logic [63:0] lo_ofs;
    logic [63:0] hi_ofs;
    bit          stop;
    step_runs.delete();
    if (s.total_count != 0 && s.cum_high <= s.total_count && s.cum_low < s.cum_high) begin
      span   = 64'(code_high) - 64'(code_low) + 64'd1;
      lo_ofs = span * 64'(s.cum_low) / 64'(s.total_count);
      hi_ofs = span * 64'(s.cum_high) / 64'(s.total_count);
      if (hi_ofs > lo_ofs) begin
        code_high = CW'(64'(code_low) + hi_ofs - 64'd1);
        code_low  = CW'(64'(code_low) + lo_ofs);
      end
      stop = 1'b0;
      for (int i = 0; i < CW && !stop; i++) begin
        if (code_low[CW-1] == code_high[CW-1]) begin
          put_run(code_high[CW-1]);
        end else if (code_low[CW-2] && !code_high[CW-2]) begin
          code_low[CW-1 -: 2] = 2'b00;
          code_high[CW-2]     = 1'b1;
          bump_pending();
        end else begin
          stop = 1'b1;
        end
        if (!stop) begin
          code_low  = code_low << 1;
          code_high = {code_high[CW-2:0], 1'b1};
        end
      end
    end else begin
      rejected_sent++;
    end
    if (s.flush) begin
      bump_pending();
      put_run(code_low[CW-2]);
      flushes_sent++;
    end
    if (step_runs.size() > 0) step_runs[step_runs.size()-1].last = 1'b1;
  endfunction

  function automatic symbol_t rand_symbol();
    symbol_t     s;
    int unsigned pick;
    int unsigned tot;
    int unsigned top;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      s.cum_low     = CUM_W'($urandom);
      s.cum_high    = TOT_W'($urandom);
      s.total_count = (pick < 3) ? '0 : TOT_W'($urandom);
    end else begin
      if (pick < 70) tot = $urandom_range(1, MAX_TOTAL);
      else if (pick < 88) tot = $urandom_range(MAX_TOTAL + 1, TOT_FULL);
      else tot = $urandom_range(1, 16);
      top = (tot - 1 < MAX_CUM) ? tot - 1 : MAX_CUM;
      s.cum_low = CUM_W'($urandom_range(0, top));
      if ($urandom_range(0, 1) == 1) s.cum_high = TOT_W'(s.cum_low + 1);
      else s.cum_high = TOT_W'($urandom_range(s.cum_low + 1, tot));
      s.total_count = TOT_W'(tot);
    end
    s.flush = ($urandom_range(0, 99) < 8);
    return s;
  endfunction

  // slice that straddles the middle of the current range: underflow only
  function automatic symbol_t centered_symbol();
    symbol_t     s;
    logic [63:0] span;
    logic [63:0] below;
    logic [63:0] lo_cum;
    logic [63:0] hi_cum;
    span   = 64'(code_high) - 64'(code_low) + 64'd1;
    below  = 64'(1 << (CW - 1)) - 64'(code_low);
    lo_cum = (below * MAX_TOTAL - 64'd1) / span;
    hi_cum = (lo_cum + 2 > MAX_TOTAL) ? 64'(MAX_TOTAL) : lo_cum + 2;
    s.cum_low     = CUM_W'(lo_cum);
    s.cum_high    = TOT_W'(hi_cum);
    s.total_count = TOT_W'(MAX_TOTAL);
    s.flush       = 1'b0;
    return s;
  endfunction

  task automatic send_symbol(input row_t r);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sym_ch.valid       <= 1'b1;
    sym_ch.cum_low     <= r.sym.cum_low;
    sym_ch.cum_high    <= r.sym.cum_high;
    sym_ch.total_count <= r.sym.total_count;
    sym_ch.flush       <= r.sym.flush;
    do @(posedge clk_i); while (!sym_ch.ready);
    symbols_sent++;
    code_symbol(r.sym);
    case (r.kind)
      ROW_MODEL: begin
        foreach (step_runs[i]) runs_due.push_back(step_runs[i]);
      end
      ROW_ONE_RUN: begin
        runs_due.push_back('{r.exp_bit, r.exp_follow, 1'b1});
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_random(input int unsigned n);
    row_t r;
    for (int i = 0; i < n; i++) begin
      r = '{rand_symbol(), ROW_MODEL, 1'b0, '0};
      send_symbol(r);
    end
  endtask

  // run transfers: check against the oldest expectation, then pick next ready
  always @(posedge clk_i) begin
    run_t got;
    run_t want;
    if (run_ch.valid && run_ch.ready) begin
      got = '{run_ch.out_bit, run_ch.follow_count, run_ch.last};
      runs_checked++;
      if (runs_due.size() == 0) begin
        $error("unexpected run: out_bit %0b follow_count %0d last %0b",
               got.out_bit, got.follow_count, got.last);
        fail_cnt++;
      end else begin
        want = runs_due.pop_front();
        if (got.out_bit !== want.out_bit) begin
          $error("out_bit: expected %0b, got %0b", want.out_bit, got.out_bit);
          fail_cnt++;
        end
        if (got.follow_count !== want.follow_count) begin
          $error("follow_count: expected %0d, got %0d", want.follow_count, got.follow_count);
          fail_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fail_cnt++;
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      run_ch.ready <= 1'b0;
    end else begin
      run_ch.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs still due", cycle_cnt, runs_due.size());
      $display("arithmetic_encoder_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    row_t        r;
    rst_ni             = 1'b0;
    sym_ch.valid       = 1'b0;
    sym_ch.cum_low     = '0;
    sym_ch.cum_high    = '0;
    sym_ch.total_count = '0;
    sym_ch.flush       = 1'b0;
    run_ch.ready       = 1'b0;
    hold_req           = 1'b0;
    hold_done          = 1'b0;
    hold_left          = 0;
    src_gap_pct        = 0;
    sink_gap_pct       = 0;
    fail_cnt           = 0;
    runs_checked       = 0;
    symbols_sent       = 0;
    flushes_sent       = 0;
    rejected_sent      = 0;
    cycle_cnt          = 0;
    code_low           = '0;
    code_high          = '1;
    pend_cnt           = '0;
    pend_peak          = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_symbol(dir_rows[i]);

    src_gap_pct = 29;
    sink_gap_pct <= 49;
    send_random(RAND_ITEMS);

    src_gap_pct = 49;
    sink_gap_pct <= 29;
    send_random(RAND_ITEMS);

    // long output hold while symbols keep coming
    src_gap_pct = 0;
    sink_gap_pct <= 0;
    hold_req <= 1'b1;
    send_random(RAND_ITEMS);

    // centered symbols build up a long pending count, then a flush
    repeat (CENTER_ITEMS) begin
      r = '{centered_symbol(), ROW_MODEL, 1'b0, '0};
      send_symbol(r);
    end
    r = '{'{'0, TOT_W'(1), '0, 1'b1}, ROW_MODEL, 1'b0, '0};
    send_symbol(r);

    sym_ch.valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("coded %0d symbols (%0d flushes, %0d rejected intervals), checked %0d runs",
             symbols_sent, flushes_sent, rejected_sent, runs_checked);
    $display("pending count peaked at %0d, %0d mismatches", pend_peak, fail_cnt);
    if (fail_cnt == 0) begin
      $display("arithmetic_encoder_core_test OK");
    end else begin
      $display("arithmetic_encoder_core_test NOT OK");
    end
    $finish;
  end

endmodule
